### rtl/ocm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocm_pkg
// Shared types and constants of the occupancy confusion metrics block.
// ----------------------------------------------------------------------------
package ocm_pkg;

	// Cell classification codes
	typedef enum logic [2:0] {
		CLS_TP  = 3'd0,
		CLS_TN  = 3'd1,
		CLS_FP  = 3'd2,
		CLS_FN  = 3'd3,
		CLS_UNK = 3'd4
	} cls_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_SUM  = 2'd1,
		BK_DIV  = 2'd2,
		BK_DONE = 2'd3
	} bk_state_t;

	localparam int unsigned CELL_W   = 18;
	localparam int unsigned PROB_W   = 17;
	localparam int unsigned Q_BITS   = 16;
	localparam int unsigned STEP_W   = 4;
	localparam int unsigned OUT_CNT_W = 32;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 184;

	localparam logic [PROB_W-1:0] THR_RESET = 17'd32768;
	localparam logic [PROB_W-1:0] Q16_ONE   = 17'd65536;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

	// Register byte-address bit that selects the register index
	localparam logic REG_THRESHOLD = 1'b0;

endpackage

### rtl/ocm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocm_queue
// Small register FIFO between the classifier front end and the metric back end.
// ----------------------------------------------------------------------------
module ocm_queue #(
	parameter int unsigned WIDTH = 132,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/ocm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocm_front
// Accepts cell pairs, classifies them against the threshold, updates the
// saturating counters and pushes class, counts and last flag to the queue.
// ----------------------------------------------------------------------------
module ocm_front
	import ocm_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [IN_DATA_W-1:0]         s_tdata,
	input  logic                         s_tuser,
	input  logic                         s_tlast,
	input  logic [PROB_W-1:0]            threshold,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [4*COUNT_WIDTH+3:0]     q_data
);

	logic [CELL_W-1:0]      truth;
	logic [CELL_W-1:0]      test;
	logic                   unknown;
	logic                   truth_obs;
	logic                   test_obs;
	logic                   accept;
	logic                   count_en;
	cls_t                   cls;
	logic [COUNT_WIDTH-1:0] tp_q, tn_q, fp_q, fn_q;
	logic [COUNT_WIDTH-1:0] tp_nxt, tn_nxt, fp_nxt, fn_nxt;

	assign truth    = s_tdata[CELL_W-1:0];
	assign test     = s_tdata[2*CELL_W-1:CELL_W];
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept;

	// Classify the pair
	assign unknown   = truth[CELL_W-1] || test[CELL_W-1];
	assign truth_obs = truth[PROB_W-1:0] > threshold;
	assign test_obs  = test[PROB_W-1:0] > threshold;

	always_comb begin
		if (unknown) begin
			cls = CLS_UNK;
		end else if (truth_obs && test_obs) begin
			cls = CLS_TP;
		end else if (!truth_obs && !test_obs) begin
			cls = CLS_TN;
		end else if (test_obs) begin
			cls = CLS_FP;
		end else begin
			cls = CLS_FN;
		end
	end

	// Bump the selected counter, hold at full scale
	assign count_en = s_tuser && !unknown;
	assign tp_nxt = (count_en && cls == CLS_TP && tp_q != '1) ? tp_q + 1'b1 : tp_q;
	assign tn_nxt = (count_en && cls == CLS_TN && tn_q != '1) ? tn_q + 1'b1 : tn_q;
	assign fp_nxt = (count_en && cls == CLS_FP && fp_q != '1) ? fp_q + 1'b1 : fp_q;
	assign fn_nxt = (count_en && cls == CLS_FN && fn_q != '1) ? fn_q + 1'b1 : fn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			tn_q <= '0;
			fp_q <= '0;
			fn_q <= '0;
		end else if (accept) begin
			tp_q <= tp_nxt;
			tn_q <= tn_nxt;
			fp_q <= fp_nxt;
			fn_q <= fn_nxt;
		end
	end

	// Queue entry: last, class, tp, tn, fp, fn from the low bit up
	assign q_data = {fn_nxt, fp_nxt, tn_nxt, tp_nxt, cls, s_tlast};

endmodule

### rtl/ocm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocm_back
// Drains the queue into the output register. On the last cell it forms the
// ratio sums and runs three restoring divider lanes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ocm_back
	import ocm_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  logic [4*COUNT_WIDTH+3:0] q_data,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_W-1:0]    m_tdata,
	output logic                     m_tuser
);

	localparam int unsigned CW   = COUNT_WIDTH;
	localparam int unsigned DW   = CW + 2;
	localparam int unsigned EXTW = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
	localparam int unsigned LANES = 3;

	bk_state_t            state_q, state_nxt;
	logic [STEP_W-1:0]    step_q;
	logic                 out_free;
	logic                 load_pass;
	logic                 load_res;
	logic                 take_last;
	logic                 entry_last;
	logic [4*CW+3:0]      hold_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	logic [DW-1:0]        den_q  [LANES];
	logic [DW-1:0]        r_q    [LANES];
	logic [Q_BITS-1:0]    quo_q  [LANES];
	logic                 full_q [LANES];
	logic [PROB_W-1:0]    ratio  [LANES];

	logic [CW-1:0]        h_tp, h_tn, h_fp, h_fn;
	logic [DW-1:0]        num_in [LANES];
	logic [DW-1:0]        den_in [LANES];

	// Widen or trim a count to the output field
	function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CW-1:0] c);
		logic [EXTW-1:0] ext;
		ext = EXTW'(c);
		return ext[OUT_CNT_W-1:0];
	endfunction

	// Pack one result: class, four counts, three ratios from the low bit up
	function automatic logic [OUT_DATA_W-1:0] pack_out(
		input logic [4*CW+3:0]   e,
		input logic [PROB_W-1:0] prec,
		input logic [PROB_W-1:0] rec,
		input logic [PROB_W-1:0] acc
	);
		logic [3*PROB_W+4*OUT_CNT_W+2:0] body;
		body = {acc, rec, prec,
			cnt_out(e[4*CW+3:3*CW+4]), cnt_out(e[3*CW+3:2*CW+4]),
			cnt_out(e[2*CW+3:CW+4]), cnt_out(e[CW+3:4]), e[3:1]};
		return OUT_DATA_W'(body);
	endfunction

	assign entry_last = q_data[0];
	assign out_free   = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid && entry_last) state_nxt = BK_SUM;
			BK_SUM:  state_nxt = BK_DIV;
			BK_DIV:  if (step_q == STEP_LAST) state_nxt = BK_DONE;
			BK_DONE: if (out_free) state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		load_pass = 1'b0;
		take_last = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				load_pass = q_valid && !entry_last && out_free;
				take_last = q_valid && entry_last;
			end
			BK_DONE: load_res = out_free;
			default: ;
		endcase
	end

	assign q_pop = load_pass || take_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == BK_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Capture the last entry
	always_ff @(posedge clk) begin
		if (take_last) begin
			hold_q <= q_data;
		end
	end

	assign h_tp = hold_q[CW+3:4];
	assign h_tn = hold_q[2*CW+3:CW+4];
	assign h_fp = hold_q[3*CW+3:2*CW+4];
	assign h_fn = hold_q[4*CW+3:3*CW+4];

	// Ratio operands: precision, recall, accuracy
	assign num_in[0] = DW'(h_tp);
	assign den_in[0] = DW'(h_tp) + DW'(h_fp);
	assign num_in[1] = DW'(h_tp);
	assign den_in[1] = DW'(h_tp) + DW'(h_fn);
	assign num_in[2] = DW'(h_tp) + DW'(h_tn);
	assign den_in[2] = (DW'(h_tp) + DW'(h_tn)) + (DW'(h_fp) + DW'(h_fn));

	// Divider lanes, one quotient bit per cycle
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [DW:0]   r_dbl;
		logic          ge;
		logic [DW:0]   r_sub;

		assign r_dbl = {r_q[l], 1'b0};
		assign ge    = r_dbl >= {1'b0, den_q[l]};
		assign r_sub = r_dbl - {1'b0, den_q[l]};

		always_ff @(posedge clk) begin
			if (state_q == BK_SUM) begin
				r_q[l]   <= num_in[l];
				den_q[l] <= den_in[l];
				quo_q[l] <= '0;
			end else if (state_q == BK_DIV) begin
				if (step_q == '0) begin
					full_q[l] <= r_q[l] >= den_q[l];
				end
				r_q[l]   <= ge ? r_sub[DW-1:0] : r_dbl[DW-1:0];
				quo_q[l] <= {quo_q[l][Q_BITS-2:0], ge};
			end
		end

		assign ratio[l] = (den_q[l] == '0) ? '0 :
			full_q[l] ? Q16_ONE : {1'b0, quo_q[l]};
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_pass || load_res) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pass) begin
			m_tdata_q <= pack_out(q_data, '0, '0, '0);
			m_tuser_q <= 1'b0;
		end else if (load_res) begin
			m_tdata_q <= pack_out(hold_q, ratio[0], ratio[1], ratio[2]);
			m_tuser_q <= (den_q[2] != '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### rtl/occupancy_confusion_metrics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_confusion_metrics_core
// Confusion-matrix counters and precision, recall and accuracy for a stream of
// ground-truth and test occupancy cell pairs.
// ----------------------------------------------------------------------------
// The front end takes one cell pair per cycle while the queue has room,
// classifies it and updates the four saturating counters on acceptance; a
// four-entry queue hands each cell to the back end, which returns one result
// per cell, one per cycle for ordinary cells while the output is not stalled.
// A last cell holds the back end for capture, operand sums, 16 steps of the
// three restoring divider lanes and result load; the front accepts until the
// queue fills. Obstacle threshold register: byte address 0, reset 0.5 (32768).
module occupancy_confusion_metrics_core
	import ocm_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Cell pair stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // truth_cell[17:0], test_cell[35:18], zero pad
	input  logic                  s_tuser,   // in_area
	input  logic                  s_tlast,   // last_cell
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // cell_class[2:0], true_pos_count[34:3],
	                                         // true_neg_count[66:35], false_pos_count[98:67],
	                                         // false_neg_count[130:99], precision_q16[147:131],
	                                         // recall_q16[164:148], accuracy_q16[181:165], pad
	output logic                  m_tuser,   // metrics_valid
	// Register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int unsigned QW = 4 * COUNT_WIDTH + 4;

	logic [PROB_W-1:0] threshold_q;
	logic              q_full;
	logic              q_push;
	logic [QW-1:0]     q_wdata;
	logic              q_pop;
	logic [QW-1:0]     q_rdata;
	logic              q_valid;

	// Register write and readback
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
			threshold_q <= pwdata[PROB_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(threshold_q) : '0;

	ocm_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.threshold(threshold_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	ocm_queue #(
		.WIDTH(QW),
		.DEPTH(4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.not_empty(q_valid)
	);

	ocm_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
